/* sv/pcbp_pkg.sv */
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants of the prefix-code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  localparam int VAL_W  = 32;                // code value bits in the table
  localparam int LEN_W  = 6;                 // code length field, 0 to 32
  localparam int PEND_W = 7;                 // bits that never make a byte
  localparam int ACC_W  = PEND_W + VAL_W;    // pending bits plus one code
  localparam int CNT_W  = 6;                 // holds 0 to ACC_W
  localparam int BYTE_W = 8;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] length;
  } entry_t;

  // lookup stage to packer
  typedef struct packed {
    logic valid;
    logic flush;
  } lookup_t;

endpackage

/* sv/pcbp_table.sv */
// ----------------------------------------------------------------------------
// pcbp_table
// Code table memory and lookup stage: writes loaded entries, reads the
// entry of an encoded symbol and holds it until the packer takes it.
// ----------------------------------------------------------------------------
module pcbp_table #(
  parameter int SYMBOL_BITS  = 8,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_fire,
  input  logic [pcbp_pkg::MODE_W-1:0]     in_mode,
  input  logic [SYMBOL_BITS-1:0]          in_symbol,
  input  logic [pcbp_pkg::VAL_W-1:0]      in_value,
  input  logic [pcbp_pkg::LEN_W-1:0]      in_length,
  input  logic                            take,
  output pcbp_pkg::lookup_t               lkp,
  output pcbp_pkg::entry_t                rd_entry
);

  localparam int DEPTH     = 1 << SYMBOL_BITS;
  localparam int LEN_LIMIT = (MAX_CODE_LEN < pcbp_pkg::VAL_W) ? MAX_CODE_LEN : pcbp_pkg::VAL_W;

  pcbp_pkg::entry_t mem [DEPTH];
  pcbp_pkg::entry_t rd_r;
  pcbp_pkg::entry_t wr_entry;
  pcbp_pkg::lookup_t lkp_r, lkp_nxt;
  logic [pcbp_pkg::LEN_W-1:0] len_sat;
  logic [pcbp_pkg::VAL_W:0]   val_mask;
  logic                       is_load;
  logic                       is_work;

  always_comb begin
    len_sat = (in_length > pcbp_pkg::LEN_W'(LEN_LIMIT)) ? pcbp_pkg::LEN_W'(LEN_LIMIT)
                                                       : in_length;
    val_mask = ((pcbp_pkg::VAL_W+1)'(1) << len_sat) - (pcbp_pkg::VAL_W+1)'(1);
    wr_entry.value  = in_value & val_mask[pcbp_pkg::VAL_W-1:0];
    wr_entry.length = len_sat;
    is_load = (in_mode == pcbp_pkg::MODE_LOAD);
    is_work = (in_mode == pcbp_pkg::MODE_ENCODE) || (in_mode == pcbp_pkg::MODE_FLUSH);
  end

  // load writes at the transfer; a following encode reads the new entry
  always_ff @(posedge clk) begin
    if (in_fire && is_load) begin
      mem[in_symbol] <= wr_entry;
    end
    if (in_fire && is_work) begin
      rd_r <= mem[in_symbol];
    end
  end

  always_comb begin
    lkp_nxt = lkp_r;
    if (in_fire && is_work) begin
      lkp_nxt.valid = 1'b1;
      lkp_nxt.flush = (in_mode == pcbp_pkg::MODE_FLUSH);
    end else if (take) begin
      lkp_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lkp_r <= '0;
    end else begin
      lkp_r <= lkp_nxt;
    end
  end

  assign lkp      = lkp_r;
  assign rd_entry = rd_r;

endmodule

/* sv/pcbp_packer.sv */
// ----------------------------------------------------------------------------
// pcbp_packer
// Bit accumulator: appends a code or flush padding, then hands out whole
// bytes one per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module pcbp_packer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcbp_pkg::lookup_t            lkp,
  input  pcbp_pkg::entry_t             entry,
  output logic                         take,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [pcbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_last
);

  logic [pcbp_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [pcbp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        ov_r, ov_nxt;
  logic [pcbp_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic                        last_r, last_nxt;

  logic                         emit_fire;
  logic [pcbp_pkg::CNT_W-1:0]   base_cnt;
  logic [pcbp_pkg::PEND_W-1:0]  pend;
  logic [pcbp_pkg::LEN_W-1:0]   len_enc;
  logic [pcbp_pkg::LEN_W-1:0]   app_len;
  logic [pcbp_pkg::VAL_W:0]     val_mask;
  logic [pcbp_pkg::VAL_W-1:0]   app_val;
  logic [pcbp_pkg::ACC_W-1:0]   new_acc;
  logic [pcbp_pkg::ACC_W-1:0]   emit_acc;

  always_comb begin
    emit_fire = (cnt_r >= pcbp_pkg::CNT_W'(8)) && (!ov_r || out_tready);
    base_cnt  = emit_fire ? (cnt_r - pcbp_pkg::CNT_W'(8)) : cnt_r;
    take      = lkp.valid && (base_cnt < pcbp_pkg::CNT_W'(8));

    // bits still pending after this cycle's byte leaves
    pend = acc_r[pcbp_pkg::PEND_W-1:0]
         & ((pcbp_pkg::PEND_W'(1) << base_cnt[2:0]) - pcbp_pkg::PEND_W'(1));

    len_enc = (entry.length > pcbp_pkg::LEN_W'(pcbp_pkg::VAL_W))
              ? pcbp_pkg::LEN_W'(pcbp_pkg::VAL_W) : entry.length;
    // flush pads with zeros up to exactly one byte
    app_len  = lkp.flush ? (pcbp_pkg::LEN_W'(8) - {3'b000, base_cnt[2:0]}) : len_enc;
    val_mask = ((pcbp_pkg::VAL_W+1)'(1) << app_len) - (pcbp_pkg::VAL_W+1)'(1);
    app_val  = lkp.flush ? '0 : (entry.value & val_mask[pcbp_pkg::VAL_W-1:0]);
    new_acc  = ({{pcbp_pkg::VAL_W{1'b0}}, pend} << app_len)
             | {{pcbp_pkg::PEND_W{1'b0}}, app_val};

    emit_acc = acc_r >> (cnt_r - pcbp_pkg::CNT_W'(8));

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (take) begin
      acc_nxt = new_acc;
      cnt_nxt = {3'b000, base_cnt[2:0]} + pcbp_pkg::CNT_W'(app_len);
    end else if (emit_fire) begin
      cnt_nxt = base_cnt;
    end

    ov_nxt   = ov_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (emit_fire) begin
      ov_nxt   = 1'b1;
      byte_nxt = emit_acc[pcbp_pkg::BYTE_W-1:0];
      last_nxt = (cnt_r < pcbp_pkg::CNT_W'(16));
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;

endmodule

/* sv/prefix_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// Table-driven prefix-code encoder with a byte packer.
// ----------------------------------------------------------------------------
//  channel | ports                          | contents
//  --------+--------------------------------+-----------------------------------
//  in      | in_tvalid/tready/tdata/tuser   | tuser mode; tdata symbol, code_value,
//          |                                | code_length
//  out     | out_tvalid/tready/tdata/tlast  | tdata out_byte; tlast last
//
//  a load writes the table at its transfer; an encode or flush reaches the
//  packer in the cycle after its transfer, through the registered table read.
//  bytes leave at one per cycle through the output register while out_tready
//  holds; a run of short codes goes at one item per cycle while the output
//  is not stalled.
//  reset clears the lookup stage, the pending count and the output valid;
//  the code table is not cleared and holds garbage until loaded.
//  out_tready low holds the byte; the accumulator then stalls and in_tready
//  drops once the lookup stage is full.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer #(
  parameter int SYMBOL_BITS  = 8,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [((SYMBOL_BITS + pcbp_pkg::VAL_W + pcbp_pkg::LEN_W + 7) / 8) * 8 - 1:0]
                               in_tdata,   // symbol, code_value, code_length
  input  logic [1:0]           in_tuser,   // mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // out_byte
  output logic                 out_tlast   // last
);

  localparam int VAL_LO = SYMBOL_BITS;
  localparam int LEN_LO = SYMBOL_BITS + pcbp_pkg::VAL_W;

  logic                 in_fire;
  logic                 take;
  pcbp_pkg::lookup_t    lkp;
  pcbp_pkg::entry_t     rd_entry;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !lkp.valid || take;

  pcbp_table #(
    .SYMBOL_BITS  (SYMBOL_BITS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_mode   (in_tuser),
    .in_symbol (in_tdata[SYMBOL_BITS-1:0]),
    .in_value  (in_tdata[VAL_LO +: pcbp_pkg::VAL_W]),
    .in_length (in_tdata[LEN_LO +: pcbp_pkg::LEN_W]),
    .take      (take),
    .lkp       (lkp),
    .rd_entry  (rd_entry)
  );

  pcbp_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .lkp        (lkp),
    .entry      (rd_entry),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

/* sv/pcbp_checker.sv */
// ----------------------------------------------------------------------------
// pcbp_checker
// Port-level checks of the prefix-code bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module pcbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic       in_work;
  logic       out_end;
  logic [7:0] open_r, open_nxt;

  // encode and flush transfers not yet closed by a last byte (upper bound)
  assign in_work = in_tvalid && in_tready
                && (in_tuser == pcbp_pkg::MODE_ENCODE || in_tuser == pcbp_pkg::MODE_FLUSH);
  assign out_end = out_tvalid && out_tready && out_tlast;

  always_comb begin
    open_nxt = open_r;
    if (in_work && !out_end && open_r != 8'hff) begin
      open_nxt = open_r + 8'd1;
    end else if (!in_work && out_end && open_r != 8'd0) begin
      open_nxt = open_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> open_r != 8'd0)
    else $error("byte with no encode or flush outstanding");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    open_r == 8'd0 && !in_work |=> !out_tvalid)
    else $error("byte appeared without a producing transfer");

endmodule

bind prefix_code_bit_packer pcbp_checker u_pcbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
